FILE: design/hamming_sec_decoder_macros.svh
// Assertion macros shared by the Hamming single-error-correcting decoder.
`ifndef HAMMING_SEC_DECODER_MACROS_SVH
`define HAMMING_SEC_DECODER_MACROS_SVH

`ifndef SYNTH
`define HSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define HSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HSD_ASSERT_IMP(lbl, ante, cons, msg)
`define HSD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/hsd_pkg.sv
// Constants and bit-mapping functions of the Hamming single-error-correcting decoder.
`default_nettype none

package hsd_pkg;

  localparam int MAX_WORD_BITS = 63;
  localparam int WORD_W        = MAX_WORD_BITS;
  localparam int IDX_W         = $clog2(WORD_W);
  localparam int LEN_W         = $clog2(WORD_W + 1);
  localparam int SYN_W         = LEN_W;
  localparam int DATA_W        = WORD_W - LEN_W;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(7);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [SYN_W-1:0]  syn_t;
  typedef logic [LEN_W-1:0]  len_t;

  // Positions whose number has bit sbit set.
  function automatic word_t cover_mask(input int sbit);
    word_t m;
    m = '0;
    for (int p = 1; p <= WORD_W; p++) begin
      m[IDX_W'(p - 1)] = (((p >> sbit) & 1) != 0);
    end
    return m;
  endfunction

  // Packs the non-power-of-two positions in ascending order.
  function automatic data_t extract_data(input word_t word);
    data_t data;
    int    n;
    data = '0;
    n    = 0;
    for (int p = 1; p <= WORD_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (n < DATA_W) begin
          data[n[IDX_W-1:0]] = word[IDX_W'(p - 1)];
        end
        n++;
      end
    end
    return data;
  endfunction

endpackage

`default_nettype wire

FILE: design/hsd_syndrome.sv
// Parity trees that form the syndrome of a length-masked codeword.
`default_nettype none

module hsd_syndrome (
  input  hsd_pkg::word_t word_i,
  output hsd_pkg::syn_t  syn_o
);

  always_comb begin
    for (int i = 0; i < hsd_pkg::SYN_W; i++) begin
      syn_o[i] = ^(word_i & hsd_pkg::cover_mask(i));
    end
  end

endmodule

`default_nettype wire

FILE: design/hamming_sec_decoder.sv
// Top level of the pipelined Hamming single-error-correcting decoder.
`default_nettype none

// The decoder accepts one codeword per cycle while in_stall is low. Three register
// stages carry each item: the first masks the codeword to the configured length, the
// second forms the syndrome with one parity tree per syndrome bit, and the third flips
// the named bit and packs the data positions into the output register. Valid bits
// travel with each stage, so a stall on the output lets the earlier stages fill before
// in_stall is raised. The word length register is written through the cfg port, which
// is always ready; write it only while no item is in flight.

`include "hamming_sec_decoder_macros.svh"

module hamming_sec_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hsd_pkg::LEN_W-1:0]    cfg_word_length,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [hsd_pkg::WORD_W-1:0]   in_codeword,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hsd_pkg::DATA_W-1:0]   out_data_bits,
  output logic [hsd_pkg::SYN_W-1:0]    out_syndrome,
  output logic                         out_corrected,
  output logic                         out_beyond_word
);

  hsd_pkg::len_t  wl_r;

  logic           s1_valid_r;
  hsd_pkg::word_t s1_word_r;
  logic           s2_valid_r;
  hsd_pkg::word_t s2_word_r;
  hsd_pkg::syn_t  s2_syn_r;
  logic           s3_valid_r;
  hsd_pkg::data_t s3_data_r;
  hsd_pkg::syn_t  s3_syn_r;
  logic           s3_fix_r;
  logic           s3_beyond_r;

  logic           s1_en;
  logic           s2_en;
  logic           s3_en;
  logic           s1_valid_nxt;
  logic           s2_valid_nxt;
  logic           s3_valid_nxt;
  hsd_pkg::word_t s1_word_nxt;
  hsd_pkg::syn_t  s2_syn_nxt;
  hsd_pkg::word_t flip_vec;
  hsd_pkg::data_t s3_data_nxt;
  logic           s3_fix_nxt;
  logic           s3_beyond_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= hsd_pkg::LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      wl_r <= cfg_word_length;
    end
  end

  assign s3_en    = !s3_valid_r || !out_stall;
  assign s2_en    = !s2_valid_r || s3_en;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_stall = !s1_en;

  assign s1_valid_nxt = s1_en ? in_valid : s1_valid_r;
  assign s2_valid_nxt = s2_en ? s1_valid_r : s2_valid_r;
  assign s3_valid_nxt = s3_en ? s2_valid_r : s3_valid_r;

  assign s1_word_nxt = in_codeword & ~({hsd_pkg::WORD_W{1'b1}} << wl_r);

  hsd_syndrome u_syndrome (
    .word_i (s1_word_r),
    .syn_o  (s2_syn_nxt)
  );

  always_comb begin
    s3_fix_nxt    = (s2_syn_r != '0) && (s2_syn_r <= wl_r);
    s3_beyond_nxt = s2_syn_r > wl_r;
    flip_vec      = '0;
    if (s3_fix_nxt) begin
      flip_vec = hsd_pkg::WORD_W'(1) << (s2_syn_r - hsd_pkg::SYN_W'(1));
    end
    s3_data_nxt = hsd_pkg::extract_data(s2_word_r ^ flip_vec);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
      s3_valid_r <= s3_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_word_r <= s1_word_nxt;
    end
    if (s2_en) begin
      s2_word_r <= s1_word_r;
      s2_syn_r  <= s2_syn_nxt;
    end
    if (s3_en) begin
      s3_data_r   <= s3_data_nxt;
      s3_syn_r    <= s2_syn_r;
      s3_fix_r    <= s3_fix_nxt;
      s3_beyond_r <= s3_beyond_nxt;
    end
  end

  assign out_valid       = s3_valid_r;
  assign out_data_bits   = s3_data_r;
  assign out_syndrome    = s3_syn_r;
  assign out_corrected   = s3_fix_r;
  assign out_beyond_word = s3_beyond_r;

  `HSD_ASSERT_IMP(a_flags_exclusive, out_valid, !(out_corrected && out_beyond_word),
    "corrected and beyond_word are both set")
  `HSD_ASSERT_IMP(a_fix_needs_syn, out_valid && out_corrected, out_syndrome != '0,
    "a correction was reported with a zero syndrome")
  `HSD_ASSERT_IMP(a_beyond_len, out_valid && out_beyond_word, out_syndrome > wl_r,
    "beyond_word is set for a syndrome inside the word")
  `HSD_ASSERT_IMP(a_stall_full, in_stall, s1_valid_r && s2_valid_r && s3_valid_r,
    "input stalled while the pipeline has an empty stage")
  `HSD_ASSERT_NXT(a_mid_hold, s2_valid_r && s3_valid_r && out_stall, s2_valid_r,
    "middle stage item lost under output stall")

endmodule

`default_nettype wire

FILE: tb/sv/tb_hamming_sec_decoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Hamming single-error-correcting decoder.
module tb_hamming_sec_decoder;

  typedef struct packed {
    hsd_pkg::data_t data_bits;
    hsd_pkg::syn_t  syndrome;
    logic           corrected;
    logic           beyond_word;
  } decoded_t;

  logic           clk             = 1'b0;
  logic           rst_n           = 1'b0;
  logic           cfg_valid       = 1'b0;
  hsd_pkg::len_t  cfg_word_length = '0;
  logic           in_valid        = 1'b0;
  hsd_pkg::word_t in_codeword     = '0;
  logic           out_stall       = 1'b0;
  logic           cfg_ready;
  logic           in_stall;
  logic           out_valid;
  hsd_pkg::data_t out_data_bits;
  hsd_pkg::syn_t  out_syndrome;
  logic           out_corrected;
  logic           out_beyond_word;

  hsd_pkg::len_t word_length   = hsd_pkg::LEN_RESET;
  decoded_t      decoded_q[$];
  int            send_idle_pct = 35;
  int            recv_idle_pct = 45;
  int            hold_left     = 0;
  int            error_count   = 0;

  hamming_sec_decoder DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_word_length (cfg_word_length),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_codeword     (in_codeword),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_bits   (out_data_bits),
    .out_syndrome    (out_syndrome),
    .out_corrected   (out_corrected),
    .out_beyond_word (out_beyond_word)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic decoded_t decode_codeword(input hsd_pkg::len_t length,
                                               input hsd_pkg::word_t codeword);
    decoded_t       r;
    hsd_pkg::word_t w;
    int unsigned    len;
    int unsigned    syn;
    int             n;
    len = length;
    if (len > hsd_pkg::MAX_WORD_BITS) len = hsd_pkg::MAX_WORD_BITS;
    r   = '0;
    w   = '0;
    syn = 0;
    n   = 0;
    for (int p = 1; p <= len; p++) begin
      w[p-1] = codeword[p-1];
      if (codeword[p-1]) syn ^= p;
    end
    syn &= 'h3f;
    r.syndrome = hsd_pkg::syn_t'(syn);
    if (syn != 0) begin
      if (syn <= len) begin
        w[syn-1]    = ~w[syn-1];
        r.corrected = 1'b1;
      end else begin
        r.beyond_word = 1'b1;
      end
    end
    for (int p = 1; p <= len; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (n < hsd_pkg::DATA_W) r.data_bits[n] = w[p-1];
        n++;
      end
    end
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_codeword(input hsd_pkg::word_t codeword);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_codeword <= codeword;
    decoded_q.push_back(decode_codeword(word_length, codeword));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_word_length(input hsd_pkg::len_t length);
    drain_results();
    cfg_valid       <= 1'b1;
    cfg_word_length <= length;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    word_length = length;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        report_error("result with no item outstanding");
      end else begin
        want = decoded_q.pop_front();
        if (out_data_bits !== want.data_bits)
          report_error($sformatf("data_bits got %h expected %h", out_data_bits,
                                 want.data_bits));
        if (out_syndrome !== want.syndrome)
          report_error($sformatf("syndrome got %0d expected %0d", out_syndrome,
                                 want.syndrome));
        if (out_corrected !== want.corrected)
          report_error($sformatf("corrected got %b expected %b", out_corrected,
                                 want.corrected));
        if (out_beyond_word !== want.beyond_word)
          report_error($sformatf("beyond_word got %b expected %b", out_beyond_word,
                                 want.beyond_word));
      end
    end
  end

  // The reset length of seven is used without any register write.
  task automatic test_reset_length();
    send_codeword('0);
    for (int p = 1; p <= 7; p++) send_codeword(hsd_pkg::word_t'(1) << (p - 1));
    send_codeword('1);
  endtask

  task automatic test_length_extremes();
    write_word_length(hsd_pkg::len_t'(0));
    send_codeword('1);
    write_word_length(hsd_pkg::len_t'(1));
    send_codeword('1);
    write_word_length(hsd_pkg::len_t'(2));
    send_codeword(hsd_pkg::word_t'(2'b10));
    write_word_length(hsd_pkg::len_t'(3));
    send_codeword(hsd_pkg::word_t'(3'b100));
    send_codeword('1);
    write_word_length(hsd_pkg::len_t'(5));
    send_codeword(hsd_pkg::word_t'(5'b01100));
    write_word_length(hsd_pkg::len_t'(hsd_pkg::MAX_WORD_BITS));
    send_codeword('1);
    send_codeword(hsd_pkg::word_t'(1) << (hsd_pkg::MAX_WORD_BITS - 1));
    send_codeword('0);
    send_codeword(hsd_pkg::word_t'({$urandom(), $urandom()}));
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_word_length(hsd_pkg::len_t'(31));
    hold_left = 120;
    repeat (40) send_codeword(hsd_pkg::word_t'({$urandom(), $urandom()}));
    drain_results();
    repeat (10) send_codeword(hsd_pkg::word_t'({$urandom(), $urandom()}));
  endtask

  // Mostly valid codewords with zero, one or two flipped bits, plus raw noise.
  task automatic test_random_decode();
    hsd_pkg::len_t  length;
    hsd_pkg::word_t raw;
    decoded_t       d;
    int             kind;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 45 : 0;
      recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 35 : 0;
      for (int k = 0; k < 8; k++) begin
        if (k == 0) length = hsd_pkg::len_t'(hsd_pkg::MAX_WORD_BITS);
        else if (k == 1) length = hsd_pkg::len_t'(3);
        else if (k == 2) length = hsd_pkg::len_t'($urandom_range(0, 7));
        else length = hsd_pkg::len_t'($urandom_range(3, hsd_pkg::MAX_WORD_BITS));
        write_word_length(length);
        repeat (50) begin
          raw  = hsd_pkg::word_t'({$urandom(), $urandom()});
          kind = $urandom_range(0, 99);
          if (kind >= 10) begin
            d = decode_codeword(length, raw);
            for (int i = 0; i < hsd_pkg::SYN_W; i++) begin
              if (d.syndrome[i] && (1 << i) <= length) raw[(1 << i) - 1] ^= 1'b1;
            end
            if (kind >= 40 && length != 0) raw[$urandom_range(0, length - 1)] ^= 1'b1;
            if (kind >= 85 && length != 0) raw[$urandom_range(0, length - 1)] ^= 1'b1;
          end
          send_codeword(raw);
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_length();
    test_length_extremes();
    test_backpressure();
    test_random_decode();
    drain_results();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
